FILE: hdl/lapt_pkg.sv
package lapt_pkg;

  localparam int MAX_LEN    = 1024;
  localparam int ROW_BITS   = $clog2(MAX_LEN);
  localparam int LEN_BITS   = ROW_BITS + 1;
  localparam int SCORE_BITS = 24;
  localparam int SUM_BITS   = SCORE_BITS + 2;
  localparam int MAX_BITS   = SCORE_BITS + 1;
  localparam int IN_BITS    = 16;
  localparam int PEN_BITS   = 15;
  localparam int IDX_BITS   = 3;
  localparam int MIN_LEN    = 3;

  // trace flag bit positions
  localparam int FLAG_DIAG  = 0;
  localparam int FLAG_HORIZ = 1;
  localparam int FLAG_VERT  = 2;

  typedef enum logic [IDX_BITS-1:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_GAP    = 3'd2,
    REG_THRESH = 3'd3
  } cfg_reg_t;

  typedef logic [ROW_BITS-1:0]   pos_t;
  typedef logic [SCORE_BITS-1:0] score_t;

  // one row entry of a bank
  typedef struct packed {
    score_t value;
    score_t best;
    pos_t   start_r;
    pos_t   start_c;
    pos_t   end_r;
    pos_t   end_c;
  } entry_t;

  localparam entry_t ZERO_ENTRY = '0;

  // position info for the cell under evaluation
  typedef struct packed {
    pos_t row;
    pos_t col;
    logic at_edge;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0] flags;
    logic       report;
    entry_t     rep;
    entry_t     wr;
  } cell_res_t;

endpackage

FILE: hdl/lapt_cell.sv
module lapt_cell
  import lapt_pkg::*;
(
  input  cell_ctl_t                  ctl,
  input  logic signed [IN_BITS-1:0]  cell_score,
  input  logic [PEN_BITS-1:0]        gap_penalty,
  input  score_t                     report_threshold,
  input  entry_t                     o_im,
  input  entry_t                     o_i,
  input  entry_t                     n_im,
  input  entry_t                     n_i,
  output cell_res_t                  res
);

  localparam logic signed [SUM_BITS-1:0] SCORE_MAX = {2'b00, {SCORE_BITS{1'b1}}};

  function automatic logic qualifies(entry_t e, score_t thr);
    return (e.best >= thr) && (e.start_r != '0) &&
           (e.start_r != e.end_r) && (e.start_c != e.end_c);
  endfunction

  logic signed [SUM_BITS-1:0] diag_sum, diag, horiz, vert, pen, mx;
  score_t r;
  entry_t wr;
  logic   report;
  entry_t rep;

  always_comb begin
    pen      = $signed({{(SUM_BITS-PEN_BITS){1'b0}}, gap_penalty});
    diag_sum = $signed({2'b00, o_im.value}) +
               $signed({{(SUM_BITS-IN_BITS){cell_score[IN_BITS-1]}}, cell_score});
    diag     = (diag_sum > SCORE_MAX) ? SCORE_MAX : diag_sum;
    horiz    = $signed({2'b00, o_i.value}) - pen;
    vert     = $signed({2'b00, n_im.value}) - pen;
    mx = '0;
    if (diag > mx) mx = diag;
    if (horiz > mx) mx = horiz;
    if (vert > mx) mx = vert;
    r = mx[SCORE_BITS-1:0];

    res.flags = '0;
    res.flags[FLAG_DIAG]  = (mx == diag);
    res.flags[FLAG_HORIZ] = (mx == horiz);
    res.flags[FLAG_VERT]  = (mx == vert);

    wr = n_i;
    if (r != '0) begin
      priority if (mx == diag) begin
        if (o_im.value == '0) begin
          wr.start_r = ctl.row;
          wr.start_c = ctl.col;
          wr.best    = r;
          wr.end_r   = ctl.row;
          wr.end_c   = ctl.col;
        end else begin
          wr.start_r = o_im.start_r;
          wr.start_c = o_im.start_c;
          if (r >= o_im.best) begin
            wr.best  = r;
            wr.end_r = ctl.row;
            wr.end_c = ctl.col;
          end else begin
            wr.best  = o_im.best;
            wr.end_r = o_im.end_r;
            wr.end_c = o_im.end_c;
          end
        end
      end else if (mx == horiz) begin
        wr.start_r = o_i.start_r;
        wr.start_c = o_i.start_c;
        if (r >= o_i.best) begin
          wr.best  = r;
          wr.end_r = ctl.row;
          wr.end_c = ctl.col;
        end else begin
          wr.best  = o_i.best;
          wr.end_r = o_i.end_r;
          wr.end_c = o_i.end_c;
        end
      end else begin
        wr.start_r = n_im.start_r;
        wr.start_c = n_im.start_c;
        if (r > n_im.best) begin
          wr.best  = r;
          wr.end_r = ctl.row;
          wr.end_c = ctl.col;
        end else begin
          wr.best  = n_im.best;
          wr.end_r = n_im.end_r;
          wr.end_c = n_im.end_c;
        end
      end
    end

    report = 1'b0;
    rep    = ZERO_ENTRY;
    if (ctl.at_edge) begin
      if (qualifies(wr, report_threshold)) begin
        report = 1'b1;
        rep    = wr;
      end
    end else if ((r == '0) && (o_im.best != '0)) begin
      if (qualifies(o_im, report_threshold)) begin
        report = 1'b1;
        rep    = o_im;
      end
      wr.best = '0;
    end
    wr.value = r;

    res.report = report;
    res.rep    = rep;
    res.wr     = wr;
  end

endmodule

FILE: hdl/local_alignment_path_tracker.sv
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid / in_stall  cell_score
// out      output     out_valid/out_stall  trace_flags, report_*, last_cell, best_cell_score
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One cell per clock sustained unless out stalls; the row store is read as a beat is
// taken, and the evaluate stage then writes back and loads the output register.
// The rate is set by the one read and one write per cycle on the two bank memories
// (1024 rows each).
// Sync reset (rst) and every config write to index 0..3 restart the alignment;
// no clearing pass, stale rows are masked by column position. Cfg is always ready.
// A stalled output holds its beat; the evaluate stage, if full, holds and in_stall rises.
module local_alignment_path_tracker
  import lapt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [IN_BITS-1:0]  cell_score,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 trace_flags,
  output logic                       report_valid,
  output logic [SCORE_BITS-1:0]      report_score,
  output logic [ROW_BITS-1:0]        report_start_row,
  output logic [ROW_BITS-1:0]        report_start_col,
  output logic [ROW_BITS-1:0]        report_end_row,
  output logic [ROW_BITS-1:0]        report_end_col,
  output logic                       last_cell,
  output logic signed [MAX_BITS-1:0] best_cell_score,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [IDX_BITS-1:0]        cfg_index,
  input  logic [SCORE_BITS-1:0]      cfg_data
);

  localparam pos_t POS_ONE = ROW_BITS'(1);
  localparam pos_t POS_TWO = ROW_BITS'(2);

  // config registers
  logic [LEN_BITS-1:0] rows_in_use, cols_in_use, rows_c, cols_c;
  logic [PEN_BITS-1:0] gap_penalty;
  score_t              report_threshold;
  pos_t                last_row, last_col;
  logic                cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= REG_THRESH);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use      <= LEN_BITS'(MAX_LEN);
      cols_in_use      <= LEN_BITS'(MAX_LEN);
      gap_penalty      <= '0;
      report_threshold <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS:   rows_in_use      <= cfg_data[LEN_BITS-1:0];
        REG_COLS:   cols_in_use      <= cfg_data[LEN_BITS-1:0];
        REG_GAP:    gap_penalty      <= cfg_data[PEN_BITS-1:0];
        REG_THRESH: report_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp lengths to [3, MAX_LEN]; inner cells run 1 .. len-2
  always_comb begin
    rows_c = rows_in_use;
    if (rows_in_use < LEN_BITS'(MIN_LEN)) rows_c = LEN_BITS'(MIN_LEN);
    else if (rows_in_use > LEN_BITS'(MAX_LEN)) rows_c = LEN_BITS'(MAX_LEN);
    cols_c = cols_in_use;
    if (cols_in_use < LEN_BITS'(MIN_LEN)) cols_c = LEN_BITS'(MIN_LEN);
    else if (cols_in_use > LEN_BITS'(MAX_LEN)) cols_c = LEN_BITS'(MAX_LEN);
  end

  assign last_row = ROW_BITS'(rows_c - LEN_BITS'(2));
  assign last_col = ROW_BITS'(cols_c - LEN_BITS'(2));

  // handshake
  logic b_vld, b_adv, b_fire, accept;
  assign b_adv    = !out_valid || !out_stall;
  assign b_fire   = b_vld && b_adv;
  assign in_stall = b_vld && !b_adv;
  assign accept   = in_valid && !in_stall;

  // position of the next cell to be taken
  pos_t row_pos, col_pos;
  logic bank;
  logic a_edge, a_last;
  assign a_edge = (row_pos == last_row) || (col_pos == last_col);
  assign a_last = (row_pos == last_row) && (col_pos == last_col);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_pos <= POS_ONE;
      col_pos <= POS_ONE;
      bank    <= 1'b0;
    end else if (accept) begin
      priority if (a_last) begin
        row_pos <= POS_ONE;
        col_pos <= POS_ONE;
        bank    <= 1'b0;
      end else if (row_pos == last_row) begin
        row_pos <= POS_ONE;
        col_pos <= col_pos + POS_ONE;
        bank    <= ~bank;
      end else begin
        row_pos <= row_pos + POS_ONE;
      end
    end
  end

  // evaluate stage registers
  cell_ctl_t                 b_ctl;
  logic                      b_bank, b_last, b_col_one, b_col_two;
  logic signed [IN_BITS-1:0] b_score;
  logic                      fwd, fwd_bank;
  entry_t                    fwd_entry;
  entry_t                    rd0, rd1;
  entry_t                    prev_o, prev_n;
  cell_res_t                 res;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (accept) begin
      b_vld <= 1'b1;
    end else if (b_fire) begin
      b_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_ctl.row     <= row_pos;
      b_ctl.col     <= col_pos;
      b_ctl.at_edge <= a_edge;
      b_bank        <= bank;
      b_last        <= a_last;
      b_col_one     <= (col_pos == POS_ONE);
      b_col_two     <= (col_pos == POS_TWO);
      b_score       <= cell_score;
      // same row written this edge: the read below sees the old word
      fwd           <= b_fire && (b_ctl.row == row_pos);
      fwd_bank      <= ~b_bank;
      fwd_entry     <= res.wr;
    end
  end

  // row stores, one per bank; only the new-column bank is written
  entry_t mem0 [MAX_LEN];
  entry_t mem1 [MAX_LEN];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd0 <= mem0[row_pos];
      rd1 <= mem1[row_pos];
    end
    if (b_fire) begin
      if (b_bank) mem0[b_ctl.row] <= res.wr;
      else        mem1[b_ctl.row] <= res.wr;
    end
  end

  // effective entries: stale rows replaced by their restart contents,
  // start cleared once the bank has been through a column swap
  entry_t raw0, raw1, raw_o, raw_n, rst_entry, o_i, n_i, o_im, n_im;

  always_comb begin
    raw0  = (fwd && !fwd_bank) ? fwd_entry : rd0;
    raw1  = (fwd &&  fwd_bank) ? fwd_entry : rd1;
    raw_o = b_bank ? raw1 : raw0;
    raw_n = b_bank ? raw0 : raw1;

    rst_entry         = ZERO_ENTRY;
    rst_entry.start_r = b_ctl.row;
    rst_entry.start_c = POS_ONE;
    rst_entry.end_r   = b_ctl.row;
    rst_entry.end_c   = POS_ONE;

    o_i = b_col_one ? rst_entry : raw_o;

    if (b_col_one) begin
      n_i = rst_entry;
    end else if (b_col_two) begin
      n_i = rst_entry;
      n_i.start_r = '0;
      n_i.start_c = '0;
    end else begin
      n_i = raw_n;
      n_i.start_r = '0;
      n_i.start_c = '0;
    end

    // row above comes from the previous cell of this column
    o_im = (b_ctl.row == POS_ONE) ? ZERO_ENTRY : prev_o;
    n_im = (b_ctl.row == POS_ONE) ? ZERO_ENTRY : prev_n;
  end

  lapt_cell u_cell (
    .ctl              (b_ctl),
    .cell_score       (b_score),
    .gap_penalty      (gap_penalty),
    .report_threshold (report_threshold),
    .o_im             (o_im),
    .o_i              (o_i),
    .n_im             (n_im),
    .n_i              (n_i),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (b_fire) begin
      prev_o <= o_i;
      prev_n <= res.wr;
    end
  end

  // running maximum of cell values
  logic signed [MAX_BITS-1:0] run_max, run_max_next;
  always_comb begin
    run_max_next = run_max;
    if ($signed({1'b0, res.wr.value}) > run_max) run_max_next = $signed({1'b0, res.wr.value});
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      run_max <= '1;
    end else if (b_fire) begin
      run_max <= b_last ? '1 : run_max_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      trace_flags      <= res.flags;
      report_valid     <= res.report;
      report_score     <= res.rep.best;
      report_start_row <= res.rep.start_r;
      report_start_col <= res.rep.start_c;
      report_end_row   <= res.rep.end_r;
      report_end_col   <= res.rep.end_c;
      last_cell        <= b_last;
      best_cell_score  <= run_max_next;
    end
  end

endmodule

FILE: hdl/lapt_checker.sv
module lapt_checker
  import lapt_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [2:0]                 trace_flags,
  input logic                       report_valid,
  input logic [SCORE_BITS-1:0]      report_score,
  input logic [ROW_BITS-1:0]        report_start_row,
  input logic [ROW_BITS-1:0]        report_start_col,
  input logic [ROW_BITS-1:0]        report_end_row,
  input logic [ROW_BITS-1:0]        report_end_col,
  input logic signed [MAX_BITS-1:0] best_cell_score
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(trace_flags) && $stable(best_cell_score))
    else $error("stalled output beat changed");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |-> report_score == '0 && report_start_row == '0 &&
      report_start_col == '0 && report_end_row == '0 && report_end_col == '0)
    else $error("report fields set without a report");

  a_report_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> report_start_row != '0 &&
      report_start_row != report_end_row && report_start_col != report_end_col)
    else $error("reported path has bad start or end");

  a_max_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !best_cell_score[MAX_BITS-1])
    else $error("running maximum negative after a cell");

endmodule

bind local_alignment_path_tracker lapt_checker u_lapt_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .trace_flags      (trace_flags),
  .report_valid     (report_valid),
  .report_score     (report_score),
  .report_start_row (report_start_row),
  .report_start_col (report_start_col),
  .report_end_row   (report_end_row),
  .report_end_col   (report_end_col),
  .best_cell_score  (best_cell_score)
);
